// File: rtl/core/ipm_pkg.sv
// Package for the ICMP probe reply matcher: widths, ICMP and IPv4 codes,
// register indexes and the structs passed between front, queue and back.
// No dependencies.
package ipm_pkg;

  // Bytes of each packet kept for matching; later bytes are dropped
  localparam int CAPTURE_BYTES = 64;
  localparam int COUNT_W       = $clog2(CAPTURE_BYTES + 1);
  // Offsets reach past the capture window (header + quoted header + 8)
  localparam int POS_W         = (COUNT_W > 8) ? COUNT_W : 8;

  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = 40;

  // Protocol codes and fixed offsets
  localparam logic [7:0] MSG_ECHO_REPLY     = 8'd0;
  localparam logic [7:0] MSG_ECHO_REQUEST   = 8'd8;
  localparam logic [7:0] ICMP_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0] PROTO_UDP          = 8'd17;
  localparam logic [POS_W-1:0] MIN_LEN      = POS_W'(28);
  localparam logic [POS_W-1:0] QUOTE_MIN    = POS_W'(28);
  localparam logic [POS_W-1:0] ICMP_HDR_LEN = POS_W'(8);
  localparam logic [POS_W-1:0] PROTO_OFFSET = POS_W'(9);
  localparam logic [POS_W-1:0] SRC_ADDR_POS = POS_W'(12);
  localparam logic [15:0] PROBE_ID_RESET    = 16'h534D;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ARMED             = 3'd0,
    REG_EXPECTED_SEQUENCE = 3'd1,
    REG_PROBE_IDENTIFIER  = 3'd2,
    REG_UDP_MODE          = 3'd3,
    REG_UDP_SOURCE_PORT   = 3'd4,
    REG_UDP_DEST_PORT     = 3'd5
  } ipm_reg_t;

  typedef struct packed {
    logic        armed;
    logic [15:0] expected_sequence;
    logic [15:0] probe_identifier;
    logic        udp_mode;
    logic [15:0] udp_source_port;
    logic [15:0] udp_dest_port;
  } ipm_cfg_t;

  // Fields pulled out of one packet by position
  typedef struct packed {
    logic [COUNT_W-1:0] n;            // captured length
    logic [5:0]         ihl;          // outer header length in bytes
    logic [7:0]         icmp_type;
    logic [15:0]        echo_id;
    logic [15:0]        echo_seq;
    logic [5:0]         qihl;         // quoted header length in bytes
    logic [7:0]         quoted_proto;
    logic [7:0][7:0]    inner;        // first 8 bytes after the quoted header
    logic [31:0]        src_addr;
  } ipm_rec_t;

  typedef struct packed {
    logic        matched;
    logic        reached_target;
    logic [31:0] hop_address;
  } ipm_result_t;

endpackage

// File: rtl/core/ipm_front.sv
// Front of the matcher: accepts packet bytes and captures header fields
// by position as they stream past. Depends on ipm_pkg.
module ipm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  input  logic [7:0]        byte_data,
  input  logic              byte_last,
  output logic              byte_ready,
  output logic              rec_push,
  output ipm_pkg::ipm_rec_t rec,
  input  logic              rec_full
);
  import ipm_pkg::*;

  logic [COUNT_W-1:0] byte_count;
  ipm_rec_t           fields;
  ipm_rec_t           fields_next;
  logic               accept;

  assign byte_ready = !rec_full;
  assign accept     = byte_valid && byte_ready;
  assign rec_push   = accept && byte_last;
  assign rec        = fields_next;

  // Work out where each field sits and capture the current byte
  always_comb begin
    logic             capture;
    logic [POS_W-1:0] pos;
    logic [5:0]       ihl_cur;
    logic [5:0]       qihl_cur;
    logic [POS_W-1:0] q_pos;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] h_pos;
    capture  = byte_count < COUNT_W'(CAPTURE_BYTES);
    pos      = POS_W'(byte_count);
    ihl_cur  = (capture && byte_count == '0) ? {byte_data[3:0], 2'b00} : fields.ihl;
    h_pos    = POS_W'(ihl_cur);
    q_pos    = h_pos + ICMP_HDR_LEN;
    qihl_cur = (capture && pos == q_pos) ? {byte_data[3:0], 2'b00} : fields.qihl;
    r_pos    = q_pos + POS_W'(qihl_cur);

    fields_next      = fields;
    fields_next.ihl  = ihl_cur;
    fields_next.qihl = qihl_cur;
    fields_next.n    = capture ? COUNT_W'(byte_count + 1'b1) : byte_count;
    if (capture) begin
      if (pos == h_pos)                fields_next.icmp_type      = byte_data;
      if (pos == h_pos + POS_W'(4))    fields_next.echo_id[15:8]  = byte_data;
      if (pos == h_pos + POS_W'(5))    fields_next.echo_id[7:0]   = byte_data;
      if (pos == h_pos + POS_W'(6))    fields_next.echo_seq[15:8] = byte_data;
      if (pos == h_pos + POS_W'(7))    fields_next.echo_seq[7:0]  = byte_data;
      if (pos == q_pos + PROTO_OFFSET) fields_next.quoted_proto   = byte_data;
      for (int k = 0; k < 8; k++) begin
        if (pos == r_pos + POS_W'(k)) fields_next.inner[k] = byte_data;
      end
      if (pos == SRC_ADDR_POS)              fields_next.src_addr[31:24] = byte_data;
      if (pos == SRC_ADDR_POS + POS_W'(1))  fields_next.src_addr[23:16] = byte_data;
      if (pos == SRC_ADDR_POS + POS_W'(2))  fields_next.src_addr[15:8]  = byte_data;
      if (pos == SRC_ADDR_POS + POS_W'(3))  fields_next.src_addr[7:0]   = byte_data;
    end
  end

  // Advance the byte position, restart at the end of a packet
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      byte_count <= byte_last ? '0 : fields_next.n;
    end
  end

  // Hold captured fields
  always_ff @(posedge clk) begin
    if (accept) begin
      fields <= fields_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= COUNT_W'(CAPTURE_BYTES))
    else $error("byte position beyond capture window");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    accept && byte_last |=> byte_count == '0)
    else $error("byte position not restarted after last byte");

endmodule

// File: rtl/core/ipm_queue.sv
// Short queue of captured packet records between front and back.
// Depends on ipm_pkg.
module ipm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ipm_pkg::ipm_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output ipm_pkg::ipm_rec_t head
);
  import ipm_pkg::*;

  ipm_rec_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr + 1'b1);
      end
      count <= QCNT_W'(count + QCNT_W'(do_push) - QCNT_W'(do_pop));
    end
  end

  // Store the pushed record
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("packet record pushed into full queue");

endmodule

// File: rtl/core/ipm_back.sv
// Back of the matcher: checks a captured record against the probe settings
// and holds the verdict in the output register. Depends on ipm_pkg.
module ipm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ipm_pkg::ipm_cfg_t    cfg,
  input  logic                 head_valid,
  input  ipm_pkg::ipm_rec_t    head,
  output logic                 pop,
  output logic                 res_valid,
  output ipm_pkg::ipm_result_t res,
  input  logic                 res_ready
);
  import ipm_pkg::*;

  ipm_result_t verdict;
  logic        load;

  assign load = head_valid && (!res_valid || res_ready);
  assign pop  = load;

  // Apply length checks and field compares
  always_comb begin
    logic [POS_W-1:0] n;
    logic [POS_W-1:0] q_pos;
    logic [POS_W-1:0] r_pos;
    logic             long_enough;
    logic             reply_ok;
    logic             quote_ok;
    logic             quote_long;
    logic             hit;
    n           = POS_W'(head.n);
    q_pos       = POS_W'(head.ihl) + ICMP_HDR_LEN;
    r_pos       = q_pos + POS_W'(head.qihl);
    long_enough = (n >= MIN_LEN) && (n >= q_pos);
    reply_ok    = (head.icmp_type == MSG_ECHO_REPLY) &&
                  (head.echo_id == cfg.probe_identifier) &&
                  (head.echo_seq == cfg.expected_sequence);
    quote_long  = (n >= q_pos + QUOTE_MIN) && (n >= r_pos + ICMP_HDR_LEN);
    if (cfg.udp_mode) begin
      quote_ok = (head.quoted_proto == PROTO_UDP) &&
                 ({head.inner[0], head.inner[1]} == cfg.udp_source_port) &&
                 ({head.inner[2], head.inner[3]} == cfg.udp_dest_port);
    end else begin
      quote_ok = (head.inner[0] == MSG_ECHO_REQUEST) &&
                 ({head.inner[4], head.inner[5]} == cfg.probe_identifier) &&
                 ({head.inner[6], head.inner[7]} == cfg.expected_sequence);
    end
    hit = cfg.armed && long_enough &&
          (reply_ok || ((head.icmp_type == ICMP_TIME_EXCEEDED) && quote_long && quote_ok));
    verdict.matched        = hit;
    verdict.reached_target = hit && reply_ok;
    verdict.hop_address    = hit ? head.src_addr : '0;
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= verdict;
    end
  end

  a_unmatched_clear: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.matched |-> res.hop_address == '0 && !res.reached_target)
    else $error("unmatched result carries address or target flag");

  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    pop |=> res_valid)
    else $error("record taken from queue without result held");

endmodule

// File: rtl/core/icmp_probe_reply_matcher.sv
// Result path: the last accepted byte of a packet queues its record, and the
// back registers the verdict when the output is free; other bytes give none.
// Throughput: one byte per cycle; s_tready falls only while the two-entry
// record queue is full because the output register is stalled.
// Reset: clears byte position, queue, output valid and registers to defaults.
// Top level: configuration registers plus front, queue and back. Uses ipm_pkg.
module icmp_probe_reply_matcher (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ipm_pkg::IN_TDATA_W-1:0]      s_tdata,   // [7:0] data_byte
  input  logic                                s_tlast,   // last_byte
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ipm_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [0] matched,
                                                         // [1] reached_target,
                                                         // [33:2] hop_address
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ipm_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ipm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ipm_pkg::*;

  ipm_cfg_t    cfg;
  logic        rec_push;
  ipm_rec_t    rec;
  logic        rec_full;
  logic        head_valid;
  ipm_rec_t    head;
  logic        pop;
  ipm_result_t res;

  assign cfg_ready = 1'b1;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.armed             <= 1'b0;
      cfg.expected_sequence <= '0;
      cfg.probe_identifier  <= PROBE_ID_RESET;
      cfg.udp_mode          <= 1'b0;
      cfg.udp_source_port   <= '0;
      cfg.udp_dest_port     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ARMED:             cfg.armed             <= cfg_data[0];
        REG_EXPECTED_SEQUENCE: cfg.expected_sequence <= cfg_data;
        REG_PROBE_IDENTIFIER:  cfg.probe_identifier  <= cfg_data;
        REG_UDP_MODE:          cfg.udp_mode          <= cfg_data[0];
        REG_UDP_SOURCE_PORT:   cfg.udp_source_port   <= cfg_data;
        REG_UDP_DEST_PORT:     cfg.udp_dest_port     <= cfg_data;
        default: ;
      endcase
    end
  end

  ipm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (s_tvalid),
    .byte_data  (s_tdata),
    .byte_last  (s_tlast),
    .byte_ready (s_tready),
    .rec_push   (rec_push),
    .rec        (rec),
    .rec_full   (rec_full)
  );

  ipm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (rec_push),
    .push_rec   (rec),
    .full       (rec_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ipm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (m_tvalid),
    .res        (res),
    .res_ready  (m_tready)
  );

  // Pack the result, zero-filled to whole bytes
  assign m_tdata = {6'b0, res.hop_address, res.reached_target, res.matched};

endmodule

// File: tb/reply_match_checker.sv
// Checker for the ICMP probe reply matcher: watches the config, byte and verdict
// channels, keeps its own copy of the registers and the captured packet, and
// compares every verdict with the one predicted for its packet. Uses ipm_pkg.
module reply_match_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatch_count,
  output int          replies_pending,
  output int          replies_checked,
  output int          hops_matched,
  output int          targets_reached
);
  timeunit 1ns;
  timeprecision 1ps;

  import ipm_pkg::*;

  ipm_cfg_t    cfg_now;
  logic [7:0]  capture [CAPTURE_BYTES];
  int          fill;
  ipm_result_t due_verdicts [$];

  function automatic logic [7:0] cap_byte(int idx);
    return (idx < CAPTURE_BYTES) ? capture[idx] : 8'h00;
  endfunction

  function automatic logic [15:0] cap_word(int idx);
    return {cap_byte(idx), cap_byte(idx + 1)};
  endfunction

  // Decide whether the captured packet of length n answers the current probe
  function automatic ipm_result_t predict_reply(int n);
    ipm_result_t verdict;
    int          hdr;
    int          quote;
    int          qhdr;
    bit          hit;
    bit          target;
    verdict = '0;
    hit     = 1'b0;
    target  = 1'b0;
    hdr     = int'(cap_byte(0) & 8'h0F) * 4;
    if (cfg_now.armed && n >= int'(MIN_LEN) && n >= hdr + 8) begin
      if (cap_byte(hdr) == MSG_ECHO_REPLY) begin
        hit    = (cap_word(hdr + 4) == cfg_now.probe_identifier) &&
                 (cap_word(hdr + 6) == cfg_now.expected_sequence);
        target = hit;
      end else if (cap_byte(hdr) == ICMP_TIME_EXCEEDED) begin
        quote = hdr + 8;
        if (n >= quote + 28) begin
          qhdr = quote + int'(cap_byte(quote) & 8'h0F) * 4;
          if (n >= qhdr + 8) begin
            if (cfg_now.udp_mode) begin
              hit = (cap_byte(quote + 9) == PROTO_UDP) &&
                    (cap_word(qhdr) == cfg_now.udp_source_port) &&
                    (cap_word(qhdr + 2) == cfg_now.udp_dest_port);
            end else begin
              hit = (cap_byte(qhdr) == MSG_ECHO_REQUEST) &&
                    (cap_word(qhdr + 4) == cfg_now.probe_identifier) &&
                    (cap_word(qhdr + 6) == cfg_now.expected_sequence);
            end
          end
        end
      end
    end
    if (hit) begin
      verdict.matched        = 1'b1;
      verdict.reached_target = target;
      verdict.hop_address    = {cap_byte(12), cap_byte(13), cap_byte(14), cap_byte(15)};
    end
    return verdict;
  endfunction

  always @(posedge clk) begin : track
    ipm_result_t want;
    int          errs;
    errs = 0;
    if (rst) begin
      cfg_now                   = '0;
      cfg_now.probe_identifier  = PROBE_ID_RESET;
      fill                      = 0;
      due_verdicts.delete();
      replies_pending <= 0;
    end else begin
      // Mirror register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ARMED:             cfg_now.armed             = cfg_data[0];
          REG_EXPECTED_SEQUENCE: cfg_now.expected_sequence = cfg_data;
          REG_PROBE_IDENTIFIER:  cfg_now.probe_identifier  = cfg_data;
          REG_UDP_MODE:          cfg_now.udp_mode          = cfg_data[0];
          REG_UDP_SOURCE_PORT:   cfg_now.udp_source_port   = cfg_data;
          REG_UDP_DEST_PORT:     cfg_now.udp_dest_port     = cfg_data;
          default: ;
        endcase
      end

      // Capture the head of the packet and predict at its last byte
      if (s_tvalid && s_tready) begin
        if (fill < CAPTURE_BYTES) begin
          capture[fill] = s_tdata;
          fill++;
        end
        if (s_tlast) begin
          due_verdicts.push_back(predict_reply(fill));
          fill = 0;
        end
      end

      // Compare each verdict with the oldest prediction
      if (m_tvalid && m_tready) begin
        if (due_verdicts.size() == 0) begin
          errs++;
          $display("%0t: verdict with no packet pending: expected none, actual %h",
                   $time, m_tdata);
        end else begin
          want = due_verdicts.pop_front();
          if (m_tdata[0] !== want.matched) begin
            errs++;
            $display("%0t: matched: expected %0b, actual %0b",
                     $time, want.matched, m_tdata[0]);
          end
          if (m_tdata[1] !== want.reached_target) begin
            errs++;
            $display("%0t: reached_target: expected %0b, actual %0b",
                     $time, want.reached_target, m_tdata[1]);
          end
          if (m_tdata[33:2] !== want.hop_address) begin
            errs++;
            $display("%0t: hop_address: expected %h, actual %h",
                     $time, want.hop_address, m_tdata[33:2]);
          end
          replies_checked <= replies_checked + 1;
          if (want.matched) hops_matched <= hops_matched + 1;
          if (want.reached_target) targets_reached <= targets_reached + 1;
        end
      end

      mismatch_count  <= mismatch_count + errs;
      replies_pending <= due_verdicts.size();
    end
  end

endmodule

// File: tb/icmp_probe_reply_matcher_test.sv
// Top of the ICMP probe reply matcher testbench: clock, reset, byte stimulus,
// register writes and random backpressure; verdicts are checked by
// reply_match_checker. Uses ipm_pkg and the matcher RTL.
module icmp_probe_reply_matcher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ipm_pkg::*;

  // Indexes that decode to no register
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum {FR_ECHO_REPLY, FR_QUOTED_ECHO, FR_QUOTED_UDP, FR_NOISE} frame_kind_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic [7:0]  s_tdata   = 8'h00;
  logic        s_tlast   = 1'b0;
  logic        m_tready  = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data  = 16'h0000;
  wire         s_tready;
  wire         m_tvalid;
  wire  [39:0] m_tdata;
  wire         cfg_ready;

  int mismatch_count;
  int replies_pending;
  int replies_checked;
  int hops_matched;
  int targets_reached;

  // Register values as last written, used to build hits
  logic [15:0] seq_now   = 16'h0000;
  logic [15:0] id_now    = PROBE_ID_RESET;
  logic        udp_now   = 1'b0;
  logic [15:0] sport_now = 16'h0000;
  logic [15:0] dport_now = 16'h0000;

  logic [7:0] frame [$];
  bit         steady       = 1'b0;
  bit         drain_stuck  = 1'b0;
  int         bytes_sent   = 0;
  int         packets_sent = 0;
  int         settings     = 0;
  int         stall_left   = 0;

  icmp_probe_reply_matcher u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  reply_match_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .replies_pending (replies_pending),
    .replies_checked (replies_checked),
    .hops_matched    (hops_matched),
    .targets_reached (targets_reached)
  );

  always #5 clk = ~clk;

  // Mostly short idle spans, now and then a long one
  function automatic int idle_span();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random stalls on the verdict side
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (steady || $urandom_range(0, 3) != 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready   <= 1'b0;
      stall_left <= idle_span() - 1;
    end
  end

  function automatic void put_byte(int pos, logic [7:0] v);
    if (pos < frame.size()) frame[pos] = v;
  endfunction

  function automatic void put_word(int pos, logic [15:0] v);
    put_byte(pos, v[15:8]);
    put_byte(pos + 1, v[7:0]);
  endfunction

  // Build a packet of the given kind around the current probe fields; extra
  // adds to (or cuts from) the length the match needs, spoil corrupts one field
  function automatic void build_frame(frame_kind_t kind, int ihl_w, int qihl_w,
                                      int extra, bit spoil);
    int hdr;
    int quote;
    int qhdr;
    int need;
    int len;
    int spots [$];
    int idx;
    hdr   = ihl_w * 4;
    quote = hdr + 8;
    qhdr  = quote + qihl_w * 4;
    case (kind)
      FR_ECHO_REPLY: need = (hdr + 8 > 28) ? hdr + 8 : 28;
      FR_NOISE:      need = 28;
      default:       need = (qhdr + 8 > quote + 28) ? qhdr + 8 : quote + 28;
    endcase
    len = (need + extra < 1) ? 1 : need + extra;
    frame.delete();
    repeat (len) frame.push_back(8'($urandom));
    put_byte(0, {4'($urandom), 4'(ihl_w)});
    case (kind)
      FR_ECHO_REPLY: begin
        put_byte(hdr, MSG_ECHO_REPLY);
        put_word(hdr + 4, id_now);
        put_word(hdr + 6, seq_now);
        spots = '{hdr, hdr + 4, hdr + 5, hdr + 6, hdr + 7};
      end
      FR_QUOTED_ECHO: begin
        put_byte(hdr, ICMP_TIME_EXCEEDED);
        put_byte(quote, {4'($urandom), 4'(qihl_w)});
        put_byte(qhdr, MSG_ECHO_REQUEST);
        put_word(qhdr + 4, id_now);
        put_word(qhdr + 6, seq_now);
        spots = '{hdr, qhdr, qhdr + 4, qhdr + 5, qhdr + 6, qhdr + 7};
      end
      FR_QUOTED_UDP: begin
        put_byte(hdr, ICMP_TIME_EXCEEDED);
        put_byte(quote, {4'($urandom), 4'(qihl_w)});
        put_byte(quote + 9, PROTO_UDP);
        put_word(qhdr, sport_now);
        put_word(qhdr + 2, dport_now);
        spots = '{hdr, quote + 9, qhdr, qhdr + 1, qhdr + 2, qhdr + 3};
      end
      default: spots = '{0};
    endcase
    if (spoil) begin
      idx = spots[$urandom_range(0, spots.size() - 1)];
      if (idx < len) frame[idx] = frame[idx] ^ 8'($urandom_range(1, 255));
    end
  endfunction

  // Offer one byte after an optional gap and hold it until taken
  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_span();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic send_packet(frame_kind_t kind, int ihl_w, int qihl_w, int extra, bit spoil);
    build_frame(kind, ihl_w, qihl_w, extra, spoil);
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
    packets_sent++;
  endtask

  // Drop valid and wait until every verdict is back, then let the pipe drain
  task automatic settle_idle();
    int guard;
    guard    = 0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (guard >= 20000) drain_stuck = 1'b1;
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] index, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      REG_EXPECTED_SEQUENCE: seq_now   = data;
      REG_PROBE_IDENTIFIER:  id_now    = data;
      REG_UDP_MODE:          udp_now   = data[0];
      REG_UDP_SOURCE_PORT:   sport_now = data;
      REG_UDP_DEST_PORT:     dport_now = data;
      default: ;
    endcase
  endtask

  function automatic int pick_hlen();
    return ($urandom_range(0, 4) != 0) ? 5 : $urandom_range(0, 15);
  endfunction

  function automatic int pick_extra();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 10);
    if (r < 87) return -$urandom_range(1, 27);
    return $urandom_range(30, 60);
  endfunction

  initial begin : stimulus
    int          r;
    frame_kind_t kind;
    frame_kind_t native;
    frame_kind_t foreign;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset state: disarmed rejects a perfect echo reply
    send_packet(FR_ECHO_REPLY, 5, 5, 0, 1'b0);
    settle_idle();
    write_reg(REG_ARMED, 16'h0001);
    settings++;
    // Default identifier and sequence now match
    send_packet(FR_ECHO_REPLY, 5, 5, 2, 1'b0);
    send_packet(FR_QUOTED_ECHO, 5, 5, 0, 1'b0);
    settle_idle();

    write_reg(REG_EXPECTED_SEQUENCE, 16'hFFFF);
    write_reg(REG_PROBE_IDENTIFIER, 16'h0000);
    write_reg(REG_UDP_SOURCE_PORT, 16'hFFFF);
    write_reg(REG_UDP_DEST_PORT, 16'h0000);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h1234);
    settings++;
    send_packet(FR_ECHO_REPLY, 5, 5, 0, 1'b0);
    send_packet(FR_ECHO_REPLY, 5, 5, 0, 1'b1);
    send_packet(FR_QUOTED_ECHO, 5, 5, 4, 1'b0);
    send_packet(FR_QUOTED_UDP, 5, 5, 0, 1'b0);
    // Short packet, header length below five, long packet, lone byte
    send_packet(FR_ECHO_REPLY, 5, 5, -1, 1'b0);
    send_packet(FR_ECHO_REPLY, 3, 5, 0, 1'b0);
    send_packet(FR_ECHO_REPLY, 5, 5, 72, 1'b0);
    send_packet(FR_NOISE, 5, 5, -27, 1'b0);
    // Quoted header too long for the capture window
    send_packet(FR_QUOTED_ECHO, 5, 15, 0, 1'b0);
    settle_idle();

    write_reg(REG_UDP_MODE, {15'($urandom), 1'b1});
    settings++;
    send_packet(FR_QUOTED_UDP, 5, 5, 3, 1'b0);
    send_packet(FR_QUOTED_UDP, 5, 5, 3, 1'b1);
    send_packet(FR_QUOTED_ECHO, 5, 5, 0, 1'b0);
    send_packet(FR_QUOTED_UDP, 6, 2, 0, 1'b0);
    settle_idle();

    // Armed bit is the low bit only
    write_reg(REG_ARMED, 16'hFFFE);
    settings++;
    send_packet(FR_QUOTED_UDP, 5, 5, 0, 1'b0);
    settle_idle();

    write_reg(REG_ARMED, 16'h0001);
    write_reg(REG_UDP_MODE, 16'h0000);
    write_reg(REG_EXPECTED_SEQUENCE, 16'h0000);
    write_reg(REG_PROBE_IDENTIFIER, 16'hFFFF);
    write_reg(REG_UDP_SOURCE_PORT, 16'h0000);
    write_reg(REG_UDP_DEST_PORT, 16'hFFFF);
    settings++;
    send_packet(FR_ECHO_REPLY, 5, 5, 0, 1'b0);
    send_packet(FR_QUOTED_ECHO, 5, 5, 0, 1'b0);

    // Random phases: new register setting, then a burst of packets
    while (bytes_sent < 1250) begin
      settle_idle();
      write_reg(REG_ARMED, {15'($urandom), 1'($urandom_range(0, 7) != 0)});
      if ($urandom_range(0, 1)) write_reg(REG_EXPECTED_SEQUENCE, pick_word());
      if ($urandom_range(0, 1)) write_reg(REG_PROBE_IDENTIFIER, pick_word());
      if ($urandom_range(0, 1)) write_reg(REG_UDP_MODE, 16'($urandom));
      if ($urandom_range(0, 1)) write_reg(REG_UDP_SOURCE_PORT, pick_word());
      if ($urandom_range(0, 1)) write_reg(REG_UDP_DEST_PORT, pick_word());
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE_LO + 3'($urandom_range(0, 1)),
                                               16'($urandom));
      settings++;
      steady  = ($urandom_range(0, 3) == 0);
      native  = udp_now ? FR_QUOTED_UDP : FR_QUOTED_ECHO;
      foreign = udp_now ? FR_QUOTED_ECHO : FR_QUOTED_UDP;
      repeat ($urandom_range(3, 8)) begin
        r = $urandom_range(0, 9);
        if (r < 3) kind = FR_ECHO_REPLY;
        else if (r < 7) kind = native;
        else if (r < 8) kind = foreign;
        else kind = FR_NOISE;
        send_packet(kind, pick_hlen(), pick_hlen(), pick_extra(),
                    $urandom_range(0, 3) == 0);
      end
    end
    steady = 1'b0;
    settle_idle();
    repeat (10) @(posedge clk);

    $display("Covered %0d packets, %0d bytes, over %0d register settings.",
             packets_sent, bytes_sent, settings);
    $display("Checked %0d verdicts: %0d matched, %0d reached the target.",
             replies_checked, hops_matched, targets_reached);
    if (drain_stuck || replies_pending != 0)
      $display("%0d verdicts never arrived", replies_pending);
    if (mismatch_count == 0 && !drain_stuck && replies_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #8_000_000;
    $display("Timeout waiting for the run to complete");
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: files.f
rtl/core/ipm_pkg.sv
rtl/core/ipm_front.sv
rtl/core/ipm_queue.sv
rtl/core/ipm_back.sv
rtl/core/icmp_probe_reply_matcher.sv
tb/reply_match_checker.sv
tb/icmp_probe_reply_matcher_test.sv
